/* rtl/core/firrs_pkg.sv */
// Shared constants, types and state encoding for the round-and-saturate FIR filter.
package firrs_pkg;

  // Number of taps in use (2..8); coefficient registers beyond it are kept but unused.
  localparam int unsigned TAPS        = 8;
  localparam int unsigned NUM_COEFS   = 8;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned PROD_W      = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W       = PROD_W + $clog2(TAPS) + 1;
  localparam int unsigned RND_W       = ACC_W + 1;
  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned QUOT_W      = RND_W - FRAC_BITS;

  localparam int unsigned IDX_W       = $clog2(TAPS);
  localparam int unsigned COEF_IDX_W  = $clog2(NUM_COEFS);
  localparam int unsigned CFG_IDX_W   = COEF_IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(TAPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DRAIN,
    S_OUT
  } fsm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;   // take the new sample, clear the accumulator
    logic             mul;    // multiply coefficient and sample at idx
    logic             add;    // accumulate the registered product
    logic             store;  // round, saturate and update the output register
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

endpackage

/* rtl/core/firrs_ctrl.sv */
// Controller: sequences the shared multiply-accumulate and the output handshake.
module firrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output firrs_pkg::dp_cmd_t cmd_o
);

  firrs_pkg::fsm_state_e state_q, state_d;
  logic [firrs_pkg::IDX_W-1:0] cnt_q, cnt_d;
  logic add_q, add_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      firrs_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = firrs_pkg::S_MUL;
          cnt_d   = '0;
        end
      end
      firrs_pkg::S_MUL: begin
        if (cnt_q == firrs_pkg::LAST_TAP) begin
          state_d = firrs_pkg::S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      firrs_pkg::S_DRAIN: begin
        state_d = firrs_pkg::S_OUT;
      end
      firrs_pkg::S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = firrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = firrs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    cmd_o.idx     = cnt_q;
    cmd_o.add     = add_q;
    unique case (state_q)
      firrs_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      firrs_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
      end
      firrs_pkg::S_DRAIN: begin
      end
      firrs_pkg::S_OUT: begin
        cmd_o.store = !out_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  // Accumulate in the cycle after each multiply.
  assign add_d = (state_q == firrs_pkg::S_MUL);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.store) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= firrs_pkg::S_IDLE;
      cnt_q       <= '0;
      add_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      add_q       <= add_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/firrs_datapath.sv */
// Datapath: coefficient registers, sample window, multiplier, accumulator, round and saturate.
module firrs_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [firrs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [firrs_pkg::COEF_W-1:0]          cfg_wdata_i,
  input  logic [firrs_pkg::SAMPLE_W-1:0]        sample_i,
  input  firrs_pkg::dp_cmd_t                    cmd_i,
  output logic [firrs_pkg::SAMPLE_W-1:0]        sample_o
);

  logic signed [firrs_pkg::COEF_W-1:0]   coef_q [firrs_pkg::NUM_COEFS];
  // win_q[k] holds the sample delayed by k, counting the newest as zero.
  logic signed [firrs_pkg::SAMPLE_W-1:0] win_q  [firrs_pkg::TAPS];
  logic signed [firrs_pkg::PROD_W-1:0]   prod_q;
  logic signed [firrs_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [firrs_pkg::SAMPLE_W-1:0]        res_q;

  logic signed [firrs_pkg::RND_W-1:0]    rnd;
  logic signed [firrs_pkg::RND_W-1:0]    trunc;
  logic signed [firrs_pkg::QUOT_W-1:0]   quot;
  logic [firrs_pkg::SAMPLE_W-1:0]        sat;

  localparam logic signed [firrs_pkg::QUOT_W-1:0] QMAX =
    firrs_pkg::QUOT_W'((1 << (firrs_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [firrs_pkg::QUOT_W-1:0] QMIN =
    firrs_pkg::QUOT_W'(-(1 << (firrs_pkg::SAMPLE_W - 1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < firrs_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i && !cfg_idx_i[firrs_pkg::CFG_IDX_W-1]) begin
      coef_q[cfg_idx_i[firrs_pkg::COEF_IDX_W-1:0]] <= cfg_wdata_i;
    end
  end

  // Shift the window on each new sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < firrs_pkg::TAPS; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < firrs_pkg::TAPS; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = '0;
    end else if (cmd_i.add) begin
      acc_d = acc_q + firrs_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= coef_q[firrs_pkg::COEF_IDX_W'(cmd_i.idx)] * win_q[cmd_i.idx];
    end
    acc_q <= acc_d;
    if (cmd_i.store) begin
      res_q <= sat;
    end
  end

  // Add half an LSB, then bias negatives so the shift truncates toward zero.
  always_comb begin
    rnd   = firrs_pkg::RND_W'(acc_q) + firrs_pkg::RND_W'(1 << (firrs_pkg::FRAC_BITS - 1));
    trunc = rnd[firrs_pkg::RND_W-1]
          ? rnd + firrs_pkg::RND_W'((1 << firrs_pkg::FRAC_BITS) - 1)
          : rnd;
    quot  = trunc[firrs_pkg::RND_W-1:firrs_pkg::FRAC_BITS];
    if (quot > QMAX) begin
      sat = QMAX[firrs_pkg::SAMPLE_W-1:0];
    end else if (quot < QMIN) begin
      sat = QMIN[firrs_pkg::SAMPLE_W-1:0];
    end else begin
      sat = quot[firrs_pkg::SAMPLE_W-1:0];
    end
  end

  assign sample_o = res_q;

endmodule

/* rtl/core/fir_filter_round_saturate.sv */
// Each sample is accepted in idle, then stepped through the multiply, drain and output states;
//   the single shared multiply-accumulate walks the taps one per cycle, and the output state
//   stores the rounded, saturated result, waiting while a stalled output still holds the last.
//   A new sample is accepted only after the last one has been stored.
// The output register holds a finished sample while the next one is accepted and computed.
// Reset (rst_ni low, asynchronous): coefficients and the sample window clear to zero,
//   the controller returns to idle and no output is valid.
module fir_filter_round_saturate (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port: index i selects coef_i; indexes above 7 are ignored.
  input  logic                                  cfg_we_i,
  input  logic [firrs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [firrs_pkg::COEF_W-1:0]          cfg_wdata_i,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [firrs_pkg::SAMPLE_W-1:0]        s_axis_tdata,   // [15:0] sample_in
  // Output stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [firrs_pkg::SAMPLE_W-1:0]        m_axis_tdata    // [15:0] sample_out
);

  firrs_pkg::dp_cmd_t cmd;

  // Controller: accept a transaction, step through the taps, hold the result until taken.
  firrs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  // Datapath: multiply, accumulate at full precision, add half an LSB, truncate toward zero, saturate.
  firrs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sample_o    (m_axis_tdata)
  );

endmodule
